// File: design/phod_pkg.sv
package phod_pkg;

  localparam int PIXEL_COLUMNS = 400;
  localparam int PIXEL_ROWS    = 192;
  localparam int COUNT_BITS    = 24;

  // Four ToT nibbles per hit word, one lane (memory bank) per nibble.
  localparam int LANES         = 4;
  localparam int COLS_PER_BANK = (PIXEL_COLUMNS + LANES - 1) / LANES;
  localparam int BANK_DEPTH    = COLS_PER_BANK * PIXEL_ROWS;
  localparam int ADDR_W        = $clog2(BANK_DEPTH);

  localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};

  localparam logic [31:0] IDLE_WORD      = 32'hFFFF_FFFF;
  localparam int          HEADER_BIT     = 25;
  localparam int          CORE_COL_SHIFT = 26;
  localparam int          CORE_ROW_SHIFT = 20;
  localparam int          REGION_SHIFT   = 16;
  localparam logic [5:0]  CORE_MASK      = 6'h3F;
  localparam logic [3:0]  EMPTY_TOT      = 4'hF;

  localparam logic REQ_WORD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef logic [LANES-1:0][COUNT_BITS-1:0] lane_data_t;

  // Control for one lane in a given cycle.
  typedef struct packed {
    logic clear;
    logic write;
  } lane_ctrl_t;

  // Decoded request held while the item is being worked on.
  typedef struct packed {
    logic             is_read;
    logic             rd_ok;
    logic [1:0]       rd_lane;
    logic [LANES-1:0] hit;
    logic [LANES-1:0] wr_ok;
  } item_t;

endpackage

// File: design/phod_ram.sv
module phod_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/phod_lane.sv
module phod_lane (
  input  logic                                clk,
  input  logic [phod_pkg::ADDR_W-1:0]         addr,
  input  phod_pkg::lane_ctrl_t                ctrl,
  output logic [phod_pkg::COUNT_BITS-1:0]     rdata
);
  import phod_pkg::*;

  logic [COUNT_BITS-1:0] wdata;
  logic                  we;

  // Saturating increment of the bin read in the previous cycle, or zero while clearing.
  always_comb begin
    if (ctrl.clear) begin
      wdata = '0;
    end else if (rdata == BIN_MAX) begin
      wdata = rdata;
    end else begin
      wdata = rdata + COUNT_BITS'(1);
    end
  end

  assign we = ctrl.clear | ctrl.write;

  phod_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BANK_DEPTH)
  ) u_bank (
    .clk  (clk),
    .addr (addr),
    .we   (we),
    .wdata(wdata),
    .rdata(rdata)
  );

endmodule

// File: design/phod_merge.sv
module phod_merge (
  input  phod_pkg::item_t      item,
  input  phod_pkg::lane_data_t lane_data,
  input  logic [31:0]          total,
  output logic [23:0]          bin_count,
  output logic [2:0]           hits_in_word,
  output logic [31:0]          total_next
);
  import phod_pkg::*;

  logic [31:0] bin_wide;
  logic [32:0] sum;

  always_comb begin
    hits_in_word = '0;
    for (int k = 0; k < LANES; k++) begin
      hits_in_word = hits_in_word + 3'(item.hit[k]);
    end
  end

  // The total saturates rather than wrapping.
  assign sum        = {1'b0, total} + 33'(hits_in_word);
  assign total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  assign bin_wide  = 32'(lane_data[item.rd_lane]);
  assign bin_count = (item.is_read && item.rd_ok) ? bin_wide[23:0] : 24'd0;

endmodule

// File: design/pixel_hit_occupancy_decoder_top.sv
// Pixel hit occupancy decoder.
// Slave channel s_*: one transaction per request. s_tuser selects the kind:
// a readout word to histogram, or a read of one occupancy bin. Idle words and
// header words produce a result with no hits.
// Master channel m_*: exactly one result transaction per request, in order,
// carrying the bin count (zero for words and out-of-range reads), the saturating
// hit total after the request and the number of hits found in the word.
// The bins live in four memory banks, one per ToT nibble, so all hits of a
// word are updated in one read-modify-write across the banks.
// The result is registered after the memory read (S_READ) and the write-back
// (S_UPD); the read-modify-write on the banks sets this. s_tready is high
// only in S_IDLE, so the block takes a new request only after the last one
// has finished its write-back and its result has gone into the output register.
// Reset clears the hit total and starts a clearing pass over all BANK_DEPTH
// bank addresses (19200 at the default size), during which s_tready is low.
// If the receiver stalls, the result waits in the output register and the
// next request stops before its write-back until the register is free.
module pixel_hit_occupancy_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // data_word[31:0], read_col[40:32], read_row[48:41], zero pad
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // bin_count[23:0], hit_total[55:24], hits_in_word[58:56], pad
);
  import phod_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]        state;
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] addr;
  item_t             item;
  logic [31:0]       hit_total;

  logic [23:0]       out_bin;
  logic [31:0]       out_total;
  logic [2:0]        out_hits;

  logic [31:0] word;
  logic [8:0]  read_col;
  logic [7:0]  read_row;
  logic [5:0]  ccol;
  logic [5:0]  crow;
  logic [3:0]  region;
  logic [8:0]  base_col;
  logic [8:0]  base_row;
  logic        is_hit_word;
  logic [8:0]  acc_col;
  logic [8:0]  acc_row;
  logic [31:0] addr_full;
  item_t       item_next;

  lane_data_t  lane_data;
  lane_ctrl_t  lane_ctrl [LANES];
  logic [ADDR_W-1:0] bank_addr;

  logic        accept;
  logic        out_free;
  logic        finish;
  logic [23:0] m_bin;
  logic [2:0]  m_hits;
  logic [31:0] total_next;

  assign word     = s_tdata[31:0];
  assign read_col = s_tdata[40:32];
  assign read_row = s_tdata[48:41];

  assign ccol        = word[CORE_COL_SHIFT +: 6] & CORE_MASK;
  assign crow        = word[CORE_ROW_SHIFT +: 6] & CORE_MASK;
  assign region      = word[REGION_SHIFT +: 4];
  assign base_col    = {ccol, region[0], 2'b00};
  assign base_row    = {crow, region[3:1]};
  assign is_hit_word = (word != IDLE_WORD) && !word[HEADER_BIT];

  assign acc_col = (s_tuser == REQ_READ) ? read_col : base_col;
  assign acc_row = (s_tuser == REQ_READ) ? {1'b0, read_row} : base_row;

  // Column bits above the lane select give the position within a bank row.
  assign addr_full = 32'(acc_row) * 32'(COLS_PER_BANK) + 32'(acc_col[8:2]);

  always_comb begin
    item_next.is_read = (s_tuser == REQ_READ);
    item_next.rd_ok   = (32'(read_col) < PIXEL_COLUMNS) && (32'(read_row) < PIXEL_ROWS);
    item_next.rd_lane = read_col[1:0];
    for (int k = 0; k < LANES; k++) begin
      item_next.hit[k] = (s_tuser == REQ_WORD) && is_hit_word &&
                         (word[12 - 4*k +: 4] != EMPTY_TOT);
      item_next.wr_ok[k] = item_next.hit[k] &&
                           (32'(base_col) + k < PIXEL_COLUMNS) &&
                           (32'(base_row) < PIXEL_ROWS);
    end
  end

  assign s_tready = (state == S_IDLE) && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == S_UPD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      hit_total <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_cnt == ADDR_W'(BANK_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        hit_total <= total_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
      addr <= addr_full[ADDR_W-1:0];
    end
    if (finish) begin
      out_bin   <= m_bin;
      out_total <= total_next;
      out_hits  <= m_hits;
    end
  end

  assign bank_addr = clearing ? clr_cnt : addr;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    always_comb begin
      lane_ctrl[k].clear = clearing;
      lane_ctrl[k].write = finish && item.wr_ok[k];
    end

    phod_lane u_lane (
      .clk  (clk),
      .addr (bank_addr),
      .ctrl (lane_ctrl[k]),
      .rdata(lane_data[k])
    );
  end

  phod_merge u_merge (
    .item        (item),
    .lane_data   (lane_data),
    .total       (hit_total),
    .bin_count   (m_bin),
    .hits_in_word(m_hits),
    .total_next  (total_next)
  );

  assign m_tdata = {5'd0, out_hits, out_total, out_bin};

endmodule
